FILE: sv/tqp_pkg.sv
package tqp_pkg;

	// Ring slots; the ring holds one entry fewer than this.
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;
	localparam int FREE_W      = 4;

	typedef logic [9:0]  elapsed_t;
	typedef logic [15:0] tone_t;
	typedef logic [14:0] dur_t;
	typedef logic [6:0]  vol_t;

	// Command codes carried on req.cmd; five to seven are spare and ignored.
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_ENQUEUE   = 3'd1,
		CMD_CLEAR     = 3'd2,
		CMD_LED_START = 3'd3,
		CMD_LED_OFF   = 3'd4,
		CMD_SPARE5    = 3'd5,
		CMD_SPARE6    = 3'd6,
		CMD_SPARE7    = 3'd7
	} cmd_t;

	// Player state as reported on rsp.player_state.
	typedef enum logic [1:0] {
		PLAY_IDLE  = 2'd0,
		PLAY_TIMED = 2'd1,
		PLAY_CONT  = 2'd2
	} play_t;

	typedef struct packed {
		tone_t tone;
		dur_t  dur;
		vol_t  vol;
	} queue_entry_t;

	localparam int ENTRY_W = $bits(queue_entry_t);

endpackage

FILE: sv/tqp_if.sv
interface tqp_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	tqp_pkg::elapsed_t elapsed_ms;
	tqp_pkg::tone_t    tone_code;
	tqp_pkg::dur_t     len_ms;
	tqp_pkg::vol_t     vol_pct;

	modport source (output valid, cmd, elapsed_ms, tone_code, len_ms, vol_pct,
		input ready);
	modport sink (input valid, cmd, elapsed_ms, tone_code, len_ms, vol_pct,
		output ready);
endinterface

interface tqp_rsp_if;
	logic           valid;
	logic           ready;
	logic           sound_on;
	tqp_pkg::tone_t tone_out;
	tqp_pkg::vol_t  volume_out;
	logic           led_lit;
	logic [3:0]     free_entries;
	logic [1:0]     player_state;

	modport source (output valid, sound_on, tone_out, volume_out, led_lit, free_entries,
		player_state, input ready);
	modport sink (input valid, sound_on, tone_out, volume_out, led_lit, free_entries,
		player_state, output ready);
endinterface

FILE: sv/tone_queue_player_top.sv
// Tone queue player.
//
// req carries one command beat: tick (advance playback and the hit LED by
// elapsed_ms), enqueue a tone, clear the queue, start or stop the LED
// countdown. rsp returns exactly one beat per command with the player
// outputs after that command: sound drive, tone code, volume, LED level,
// free queue entries and player state.
//
// Each command has an accept cycle, which presents the read pointer to the
// queue RAM, and an execute cycle, which uses the registered read data to
// update the player and load the response register. The registered read of
// the queue RAM is why execute follows accept, and no new command is taken
// until execute is done. The response register frees req from rsp: a new
// beat is taken in the same cycle that the pending response is taken.
//
// Reset clears pointers, player, LED and response valid; queue contents are
// not cleared, since only written slots are ever read. While rsp stalls, the
// response holds and req stays not ready.
module tone_queue_player_top (
	input  logic       clk,
	input  logic       arst_n,
	tqp_req_if.sink    req,
	tqp_rsp_if.source  rsp
);

	typedef enum logic {S_IN, S_EXEC} seq_t;

	localparam tqp_pkg::vol_t VOL_MAX = 7'd100;

	function automatic logic [tqp_pkg::PTR_W-1:0] next_slot(
		input logic [tqp_pkg::PTR_W-1:0] p);
		return (p == tqp_pkg::PTR_W'(tqp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [tqp_pkg::CNT_W-1:0] queued(
		input logic [tqp_pkg::PTR_W-1:0] w,
		input logic [tqp_pkg::PTR_W-1:0] r);
		logic [tqp_pkg::CNT_W-1:0] we, re;
		we = {1'b0, w};
		re = {1'b0, r};
		return (w >= r) ? (we - re) : (we + tqp_pkg::CNT_W'(tqp_pkg::QUEUE_DEPTH) - re);
	endfunction

	seq_t seq_q;
	logic out_valid_q;

	// Command beat, captured at accept.
	tqp_pkg::cmd_t     cmd_s1;
	tqp_pkg::elapsed_t elapsed_s1;
	tqp_pkg::tone_t    tone_s1;
	tqp_pkg::dur_t     dur_s1;
	tqp_pkg::vol_t     vol_s1;

	// Player state.
	logic [tqp_pkg::PTR_W-1:0] wp_q, rp_q;
	tqp_pkg::play_t            mode_q;
	tqp_pkg::dur_t             tone_rem_q;
	tqp_pkg::tone_t            cur_tone_q;
	tqp_pkg::vol_t             cur_vol_q;
	logic                      sounding_q;
	tqp_pkg::dur_t             led_rem_q;
	logic                      led_phase_q;

	// Response register.
	logic                        sound_on_q;
	tqp_pkg::tone_t              tone_out_q;
	tqp_pkg::vol_t               volume_out_q;
	logic                        led_lit_q;
	logic [tqp_pkg::FREE_W-1:0]  free_q;
	logic [1:0]                  state_out_q;

	// Next values.
	logic [tqp_pkg::PTR_W-1:0] wp_n, rp_n;
	tqp_pkg::play_t            mode_n;
	tqp_pkg::dur_t             tone_rem_n;
	tqp_pkg::tone_t            cur_tone_n;
	tqp_pkg::vol_t             cur_vol_n;
	logic                      sounding_n;
	tqp_pkg::dur_t             led_rem_n;
	logic                      led_phase_n;

	logic                        take;
	logic                        has_entry;
	tqp_pkg::dur_t               elapsed_ext;
	tqp_pkg::dur_t               led_dec;
	logic [tqp_pkg::CNT_W-1:0]   free_full;
	logic                        ram_we;
	tqp_pkg::queue_entry_t       wr_entry;
	tqp_pkg::queue_entry_t       rd_entry;
	logic [tqp_pkg::ENTRY_W-1:0] rd_raw;
	logic                        in_fire, out_fire;

	assign in_fire  = req.valid && req.ready;
	assign out_fire = rsp.valid && rsp.ready;

	// Take a beat only when idle and the response slot is free or being freed.
	assign req.ready = (seq_q == S_IN) && (!out_valid_q || rsp.ready);

	// The read address is the read pointer; it moves only at the end of an
	// execute cycle, so the data seen in execute belongs to the current head.
	tqp_ram #(
		.WIDTH (tqp_pkg::ENTRY_W),
		.DEPTH (tqp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (wr_entry),
		.raddr (rp_q),
		.rdata (rd_raw)
	);

	assign rd_entry = tqp_pkg::queue_entry_t'(rd_raw);

	assign has_entry   = (queued(wp_q, rp_q) != '0);
	assign elapsed_ext = {5'd0, elapsed_s1};
	assign led_dec     = (led_rem_q > elapsed_ext) ? (led_rem_q - elapsed_ext) : '0;

	always_comb begin
		wr_entry.tone = tone_s1;
		wr_entry.dur  = dur_s1;
		wr_entry.vol  = (vol_s1 > VOL_MAX) ? VOL_MAX : vol_s1;

		ram_we      = 1'b0;
		take        = 1'b0;
		wp_n        = wp_q;
		rp_n        = rp_q;
		mode_n      = mode_q;
		tone_rem_n  = tone_rem_q;
		cur_tone_n  = cur_tone_q;
		cur_vol_n   = cur_vol_q;
		sounding_n  = sounding_q;
		led_rem_n   = led_rem_q;
		led_phase_n = led_phase_q;

		if (seq_q == S_EXEC) begin
			case (cmd_s1)
				tqp_pkg::CMD_TICK: begin
					case (mode_q)
						tqp_pkg::PLAY_TIMED: begin
							if (tone_rem_q <= elapsed_ext) begin
								if (has_entry) begin
									take = 1'b1;
								end else begin
									// Tone ran out with nothing queued: go silent.
									sounding_n = 1'b0;
									cur_tone_n = '0;
									cur_vol_n  = '0;
									tone_rem_n = '0;
									mode_n     = tqp_pkg::PLAY_IDLE;
								end
							end else begin
								tone_rem_n = tone_rem_q - elapsed_ext;
							end
						end
						tqp_pkg::PLAY_CONT: begin
							// Keep sounding; the queued entry starts on the next tick.
							if (has_entry) begin
								mode_n = tqp_pkg::PLAY_IDLE;
							end
						end
						default: begin
							mode_n = tqp_pkg::PLAY_IDLE;
							take   = has_entry;
						end
					endcase

					if (!led_phase_q) begin
						if (led_rem_q != '0) begin
							led_phase_n = 1'b1;
							led_rem_n   = led_dec;
						end
					end else begin
						led_phase_n = 1'b0;
						led_rem_n   = led_dec;
					end
				end
				tqp_pkg::CMD_ENQUEUE: begin
					// Full ring: drop the oldest entry.
					if (next_slot(wp_q) == rp_q) begin
						rp_n = next_slot(rp_q);
					end
					ram_we = 1'b1;
					wp_n   = next_slot(wp_q);
				end
				tqp_pkg::CMD_CLEAR: begin
					rp_n = wp_q;
				end
				tqp_pkg::CMD_LED_START: begin
					led_rem_n = dur_s1;
				end
				tqp_pkg::CMD_LED_OFF: begin
					led_rem_n = '0;
				end
				default: begin
				end
			endcase

			if (take) begin
				rp_n       = next_slot(rp_q);
				cur_tone_n = rd_entry.tone;
				cur_vol_n  = rd_entry.vol;
				sounding_n = (rd_entry.tone != '0);
				if (rd_entry.dur != '0) begin
					tone_rem_n = rd_entry.dur;
					mode_n     = tqp_pkg::PLAY_TIMED;
				end else begin
					tone_rem_n = '0;
					mode_n     = tqp_pkg::PLAY_CONT;
				end
			end
		end
	end

	assign free_full = tqp_pkg::CNT_W'(tqp_pkg::QUEUE_DEPTH - 1) - queued(wp_n, rp_n);

	// Capture the command beat.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1     <= tqp_pkg::cmd_t'(req.cmd);
			elapsed_s1 <= req.elapsed_ms;
			tone_s1    <= req.tone_code;
			dur_s1     <= req.len_ms;
			vol_s1     <= req.vol_pct;
		end
	end

	// Player state: advance at the end of each execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			mode_q      <= tqp_pkg::PLAY_IDLE;
			tone_rem_q  <= '0;
			cur_tone_q  <= '0;
			cur_vol_q   <= '0;
			sounding_q  <= 1'b0;
			led_rem_q   <= '0;
			led_phase_q <= 1'b0;
		end else begin
			wp_q        <= wp_n;
			rp_q        <= rp_n;
			mode_q      <= mode_n;
			tone_rem_q  <= tone_rem_n;
			cur_tone_q  <= cur_tone_n;
			cur_vol_q   <= cur_vol_n;
			sounding_q  <= sounding_n;
			led_rem_q   <= led_rem_n;
			led_phase_q <= led_phase_n;
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= S_IN;
			out_valid_q  <= 1'b0;
			sound_on_q   <= 1'b0;
			tone_out_q   <= '0;
			volume_out_q <= '0;
			led_lit_q    <= 1'b0;
			free_q       <= '0;
			state_out_q  <= '0;
		end else begin
			case (seq_q)
				S_IN: begin
					if (out_fire) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						seq_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					seq_q        <= S_IN;
					out_valid_q  <= 1'b1;
					sound_on_q   <= sounding_n;
					tone_out_q   <= sounding_n ? cur_tone_n : '0;
					volume_out_q <= sounding_n ? cur_vol_n : '0;
					led_lit_q    <= led_phase_n;
					free_q       <= tqp_pkg::FREE_W'(free_full);
					state_out_q  <= mode_n;
				end
				default: begin
					seq_q <= S_IN;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.sound_on     = sound_on_q;
	assign rsp.tone_out     = tone_out_q;
	assign rsp.volume_out   = volume_out_q;
	assign rsp.led_lit      = led_lit_q;
	assign rsp.free_entries = free_q;
	assign rsp.player_state = state_out_q;

	// An accepted beat is executed in the next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (seq_q == S_EXEC))
		else $error("accepted beat not executed");

	// Every execute cycle leaves a response pending.
	a_exec_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_EXEC) |=> out_valid_q)
		else $error("execute cycle produced no response");

	// Only a timed tone carries a countdown.
	a_rem_untimed: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != tqp_pkg::PLAY_TIMED) |-> (tone_rem_q == '0))
		else $error("countdown left outside timed mode");

	// A timed tone never sits at zero remaining.
	a_rem_timed: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tqp_pkg::PLAY_TIMED) |-> (tone_rem_q != '0))
		else $error("timed mode with expired countdown");

endmodule

FILE: sv/tqp_ram.sv
module tqp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
